[design/bba_pkg.sv]
// Package for the bitmap bit allocator: field widths, codes, beat and
// control structs shared by the allocator modules. No dependencies.
`default_nettype none

package bba_pkg;

  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned OFF_W        = 5;
  localparam int unsigned MAP_BITS_DEF = 4096;
  localparam int unsigned LEN_W        = 13;
  localparam int unsigned IDX_W        = 12;
  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOSPACE  = 2'd1,
    STAT_NOTALLOC = 2'd2,
    STAT_RANGE    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] bit_index;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] allocated_bit;
  } rsp_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
  } scan_t;

endpackage

`default_nettype wire

[design/bba_ram.sv]
// Bitmap word store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module bba_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/bba_scan.sv]
// Lowest-clear-bit finder for one bitmap word, limited to the bits still
// below the length. Uses bba_pkg.
`default_nettype none

module bba_scan import bba_pkg::*; #(
  parameter int unsigned CMPW = 17
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [CMPW-1:0]      remain_i,
  output scan_t                scan_o
);

  logic [WORD_BITS-1:0] free_w;
  logic [WORD_BITS-1:0] low_w;
  logic [OFF_W-1:0]     off;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      free_w[j] = ~word_i[j] & (CMPW'(j) < remain_i);
    end
    low_w = free_w & (~free_w + WORD_BITS'(1));
    off   = '0;
    for (int b = 0; b < OFF_W; b++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (((j >> b) & 1) == 1) begin
          off[b] = off[b] | low_w[j];
        end
      end
    end
    scan_o.found  = |free_w;
    scan_o.offset = off;
  end

endmodule

`default_nettype wire

[design/bitmap_bit_allocator.sv]
// Bitmap bit allocator top level: sequencer, length register, output
// register. Uses bba_pkg, bba_ram and bba_scan.
//
// Input beats (in_valid_i/in_ready_o, in_i) carry an op and a bit index:
// allocate takes the lowest clear bit below the length, free clears the
// named bit. Each input beat gives exactly one output beat (out_valid_o/
// out_ready_i, out_o) with a status and the allocated index.
// The bitmap lives in a one-port-read, one-port-write RAM of
// ceil(MAP_BITS/32) words with registered read data; an operation writes
// back at most one word that it has read, one operation at a time.
// Steps per beat, from input accept to the result: a free with index out
// of range, or an allocate with zero length, goes straight to the result;
// a free reads, tests and writes back, then gives the result; allocate
// scans from word 0, reading one word per cycle, until the word holding
// the first free bit or the end of the length, then gives the result.
// After reset a clearing pass writes zero to every word, with in_ready_o
// low; length writes are taken.
// A result waiting in the output register does not block accepting the
// next beat; that beat's result is held until the register frees up.
`default_nettype none

module bitmap_bit_allocator import bba_pkg::*; #(
  parameter int unsigned MAP_BITS = MAP_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsp_t             out_o
);

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned LW   = $clog2(MAP_BITS + 1);
  localparam int unsigned MW0  = (LW > LEN_W) ? LW : LEN_W;
  localparam int unsigned CMPW = (MW0 > CW + OFF_W) ? MW0 : CW + OFF_W;

  state_e               state_q, state_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic [LEN_W-1:0]     len_q;
  req_t                 req_q, req_d;
  rsp_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_q, out_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [CMPW-1:0]      len_ext, eff_len, base, nxt_base, remain, alloc_w;
  logic [CMPW-1:0]      idx_ext, idx_word_w;
  logic [CW-1:0]        scan_nxt;
  logic [IDX_W-1:0]     cur_idx;
  logic [AW-1:0]        idx_addr;
  logic [OFF_W-1:0]     idx_off;
  logic                 in_acc, out_load;
  scan_t                scan;

  bba_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW),
    .DW    (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bba_scan #(
    .CMPW (CMPW)
  ) u_scan (
    .word_i   (ram_rdata),
    .remain_i (remain),
    .scan_o   (scan)
  );

  assign len_ext    = CMPW'(len_q);
  assign eff_len    = (len_ext > CMPW'(MAP_BITS)) ? CMPW'(MAP_BITS) : len_ext;
  assign scan_nxt   = scan_q + CW'(1);
  assign base       = CMPW'({scan_q, {OFF_W{1'b0}}});
  assign nxt_base   = CMPW'({scan_nxt, {OFF_W{1'b0}}});
  assign remain     = eff_len - base;
  assign alloc_w    = base + CMPW'(scan.offset);
  assign cur_idx    = (state_q == ST_IDLE) ? in_i.bit_index : req_q.bit_index;
  assign idx_ext    = CMPW'(cur_idx);
  assign idx_word_w = idx_ext >> OFF_W;
  assign idx_addr   = idx_word_w[AW-1:0];
  assign idx_off    = cur_idx[OFF_W-1:0];
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    req_d      = req_q;
    res_d      = res_q;
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_addr;
    ram_wdata  = ram_rdata;
    ram_raddr  = idx_addr;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q[AW-1:0];
        ram_wdata = '0;
        if (scan_q == CW'(MAP_WORDS - 1)) begin
          scan_d  = '0;
          state_d = ST_IDLE;
        end else begin
          scan_d = scan_nxt;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_i.op == OP_ALLOC) begin
          ram_raddr = '0;
        end
        if (in_acc) begin
          req_d               = in_i;
          res_d.allocated_bit = '0;
          scan_d              = '0;
          if (in_i.op == OP_ALLOC) begin
            if (eff_len == '0) begin
              res_d.status = STAT_NOSPACE;
              state_d      = ST_RESP;
            end else begin
              state_d = ST_SCAN;
            end
          end else if (idx_ext >= eff_len) begin
            res_d.status = STAT_RANGE;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_FREE;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = scan_nxt[AW-1:0];
        if (scan.found) begin
          ram_we              = 1'b1;
          ram_waddr           = scan_q[AW-1:0];
          ram_wdata           = ram_rdata | (WORD_BITS'(1) << scan.offset);
          res_d.status        = STAT_OK;
          res_d.allocated_bit = alloc_w[IDX_W-1:0];
          state_d             = ST_RESP;
        end else if (nxt_base >= eff_len) begin
          res_d.status        = STAT_NOSPACE;
          res_d.allocated_bit = '0;
          state_d             = ST_RESP;
        end else begin
          scan_d = scan_nxt;
        end
      end
      ST_FREE: begin
        res_d.allocated_bit = '0;
        if (ram_rdata[idx_off]) begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata & ~(WORD_BITS'(1) << idx_off);
          res_d.status = STAT_OK;
        end else begin
          res_d.status = STAT_NOTALLOC;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scan_q      <= '0;
      len_q       <= LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("bitmap written while idle");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("second beat taken while one is in flight");

  a_scan_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_q < CW'(MAP_WORDS)))
    else $error("scan pointer past the bitmap");

  a_fail_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (res_q.status != STAT_OK) |=> (out_o.allocated_bit == '0))
    else $error("failed beat carries a nonzero index");

endmodule

`default_nettype wire
